// ----- design/rpd_pkg.sv -----
// rpd_pkg: shared constants, payload types and combine helpers for the 2x2 pyramid downsampler
package rpd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int W_BITS     = 13;
  localparam int H_BITS     = 16;
  localparam int CFG_W      = 16;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = 16;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // pair partial: two samples summed, block partial: four samples summed
  localparam int PAIR_BITS  = SAMPLE_BITS + 1;
  localparam int BLK_BITS   = SAMPLE_BITS + 2;

  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  // divide by three as multiply by reciprocal, exact for values below 2^(shift-1)
  localparam int     DIV3_SHIFT = 2 * ((BLK_BITS + 3) / 2);
  localparam longint DIV3_K_L   = ((longint'(1) << DIV3_SHIFT) + 2) / 3;
  localparam logic [DIV3_SHIFT-2:0] DIV3_K = DIV3_K_L[DIV3_SHIFT-2:0];

  typedef enum logic [1:0] {
    CFG_IN_WIDTH     = 2'd0,
    CFG_IN_HEIGHT    = 2'd1,
    CFG_COMBINE_MODE = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_AVG = 1'b0,
    MODE_MAX = 1'b1
  } mode_t;

  typedef enum logic {
    BLK_UPPER = 1'b0,
    BLK_PAD   = 1'b1
  } blk_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] red_sample;
    logic signed [SAMPLE_BITS-1:0] green_sample;
    logic signed [SAMPLE_BITS-1:0] blue_sample;
    logic                          red_invalid;
    logic                          green_invalid;
    logic                          blue_invalid;
  } rpd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] red_out;
    logic signed [SAMPLE_BITS-1:0] green_out;
    logic signed [SAMPLE_BITS-1:0] blue_out;
    logic                          red_out_invalid;
    logic                          green_out_invalid;
    logic                          blue_out_invalid;
    logic                          last_of_image;
  } rpd_out_t;

  typedef struct packed {
    logic [COL_BITS:0]   width;
    logic [ROW_BITS-1:0] height;
    mode_t               mode;
  } cfg_t;

  typedef struct packed {
    logic signed [PAIR_BITS-1:0] v;
    logic [1:0]                  n;
  } pair_ch_t;

  typedef pair_ch_t [2:0] pair_pix_t;

  typedef struct packed {
    logic signed [BLK_BITS-1:0] v;
    logic [2:0]                 n;
  } blk_ch_t;

  typedef blk_ch_t [2:0] blk_pix_t;

  typedef struct packed {
    blk_pix_t ch;
    logic     last;
  } blk_item_t;

  function automatic blk_ch_t comb_ch(blk_ch_t a, blk_ch_t b, mode_t mode);
    blk_ch_t r;
    r = '0;
    if (mode == MODE_AVG) begin
      r.v = a.v + b.v;
      r.n = a.n + b.n;
    end else if (a.n != 3'd0 && b.n != 3'd0) begin
      r.v = (a.v > b.v) ? a.v : b.v;
      r.n = 3'd1;
    end else if (a.n != 3'd0) begin
      r.v = a.v;
      r.n = 3'd1;
    end else if (b.n != 3'd0) begin
      r.v = b.v;
      r.n = 3'd1;
    end
    return r;
  endfunction

  function automatic blk_ch_t widen(pair_ch_t p);
    blk_ch_t r;
    r.v = BLK_BITS'(p.v);
    r.n = 3'(p.n);
    return r;
  endfunction

  function automatic pair_ch_t narrow(blk_ch_t b);
    pair_ch_t r;
    r.v = b.v[PAIR_BITS-1:0];
    r.n = b.n[1:0];
    return r;
  endfunction

endpackage

// ----- design/rgb_pyramid_downsample_2x2.sv -----
// rgb_pyramid_downsample_2x2: top level of the 2x2 box / maximum pyramid downsampler
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  rpd_in_t, one rgb pixel in raster order
//  out_     output     out_valid/out_stall  rpd_out_t, one half-size pixel
//  cfg_     input      cfg_we               cfg_index selects, cfg_wdata carries value
//
//  one pixel transfer per clock while in_stall is low; a block leaves after its last
//  pixel through the line buffer read register, the queue and two finishing stages
//  the 4-entry queue parts front and back; in_stall rises when it could overflow
//  out_stall holds the output register and then the back end, the front keeps
//  taking pixels until the queue fills
//  synchronous reset clears counters and handshake state; the line buffer has no
//  clearing pass, each entry is written on the even row before it is read
module rgb_pyramid_downsample_2x2 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rpd_pkg::rpd_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rpd_pkg::rpd_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rpd_pkg::CFG_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [rpd_pkg::W_BITS-1:0] width_r, width_nxt;
  logic [rpd_pkg::H_BITS-1:0] height_r, height_nxt;
  rpd_pkg::mode_t             mode_r, mode_nxt;
  rpd_pkg::cfg_t              cfg;

  // front to queue, queue to back
  logic                       q_push;
  logic                       q_pop;
  logic [rpd_pkg::QAW:0]      q_count;
  rpd_pkg::blk_item_t         q_item;
  rpd_pkg::blk_item_t         q_head;

  // register writes; an index past the list is dropped
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    if (cfg_we) begin
      case (cfg_index)
        rpd_pkg::CFG_IN_WIDTH:     width_nxt  = cfg_wdata[rpd_pkg::W_BITS-1:0];
        rpd_pkg::CFG_IN_HEIGHT:    height_nxt = cfg_wdata[rpd_pkg::H_BITS-1:0];
        rpd_pkg::CFG_COMBINE_MODE: mode_nxt   = rpd_pkg::mode_t'(cfg_wdata[0]);
        default:                   mode_nxt   = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rpd_pkg::W_BITS'(1);
      height_r <= rpd_pkg::H_BITS'(1);
      mode_r   <= rpd_pkg::MODE_AVG;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // effective sizes: zero acts as one, width clamps to the line buffer
  always_comb begin
    if (width_r == '0) begin
      cfg.width = (rpd_pkg::COL_BITS + 1)'(1);
    end else if (width_r > rpd_pkg::W_BITS'(rpd_pkg::MAX_WIDTH)) begin
      cfg.width = (rpd_pkg::COL_BITS + 1)'(rpd_pkg::MAX_WIDTH);
    end else begin
      cfg.width = (rpd_pkg::COL_BITS + 1)'(width_r);
    end
    cfg.height = (height_r == '0) ? rpd_pkg::ROW_BITS'(1) : height_r;
    cfg.mode   = mode_r;
  end

  // front: raster position, pair partials, line buffer, block assembly
  rpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // decoupling queue of finished block partials
  rpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .count     (q_count),
    .head_item (q_head)
  );

  // back: divide with rounding or pass the maximum, saturate, output transfer
  rpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (cfg.mode),
    .q_count   (q_count),
    .head_item (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/rpd_front.sv -----
// rpd_front: raster tracking, pair combine, line buffer and block assembly
module rpd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rpd_pkg::rpd_in_t            in_data,
  input  rpd_pkg::cfg_t               cfg,
  input  logic [rpd_pkg::QAW:0]       q_count,
  output logic                        q_push,
  output rpd_pkg::blk_item_t          q_item
);

  logic [rpd_pkg::COL_BITS-1:0] col_r, col_nxt;
  logic [rpd_pkg::ROW_BITS-1:0] row_r, row_nxt;
  rpd_pkg::pair_pix_t           left_r, left_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  rpd_pkg::blk_kind_t           s1_kind_r;
  rpd_pkg::pair_pix_t           s1_pair_r;
  logic                         s1_last_r;

  rpd_pkg::pair_pix_t           line_mem [rpd_pkg::LINE_DEPTH];
  rpd_pkg::pair_pix_t           rd_data_r;

  logic [rpd_pkg::QAW+1:0]      q_need;
  logic                         acc;
  logic [rpd_pkg::COL_BITS:0]   col_p1;
  logic [rpd_pkg::ROW_BITS:0]   row_p1;
  logic                         row_end;
  logic                         img_end;
  logic                         done;
  logic                         emit;
  logic                         mem_we;
  logic                         mem_re;
  logic [rpd_pkg::LINE_AW-1:0]  mem_idx;
  rpd_pkg::blk_kind_t           kind;

  logic signed [rpd_pkg::SAMPLE_BITS-1:0] smp [3];
  logic                                   inv [3];
  rpd_pkg::blk_pix_t            leaf;
  rpd_pkg::blk_pix_t            pair;
  rpd_pkg::pair_pix_t           pair_n;
  rpd_pkg::blk_ch_t             zero_one;
  rpd_pkg::blk_ch_t             pad_zero;
  rpd_pkg::blk_pix_t            blk;

  // hold off when the queue has no room for the block still in flight
  always_comb begin
    q_need   = {1'b0, q_count} + (rpd_pkg::QAW + 2)'(s1_valid_r);
    in_stall = (q_need >= (rpd_pkg::QAW + 2)'(rpd_pkg::QDEPTH));
    acc      = in_valid & ~in_stall;
  end

  always_comb begin
    col_p1  = {1'b0, col_r} + 1'b1;
    row_p1  = {1'b0, row_r} + 1'b1;
    row_end = (col_p1 >= cfg.width);
    img_end = (row_p1 >= {1'b0, cfg.height});
  end

  always_comb begin
    smp[0] = in_data.red_sample;
    smp[1] = in_data.green_sample;
    smp[2] = in_data.blue_sample;
    inv[0] = in_data.red_invalid;
    inv[1] = in_data.green_invalid;
    inv[2] = in_data.blue_invalid;
    zero_one.v = '0;
    zero_one.n = 3'd1;
    for (int c = 0; c < 3; c++) begin
      if (inv[c]) begin
        leaf[c].v = '0;
        leaf[c].n = 3'd0;
      end else begin
        leaf[c].v = rpd_pkg::BLK_BITS'(smp[c]);
        leaf[c].n = 3'd1;
      end
    end
    if (!col_r[0]) begin
      // left pixel of a pair, closed with padding at an odd row end
      done = row_end;
      for (int c = 0; c < 3; c++) begin
        pair[c] = row_end ? rpd_pkg::comb_ch(leaf[c], zero_one, cfg.mode) : leaf[c];
      end
    end else begin
      done = 1'b1;
      for (int c = 0; c < 3; c++) begin
        pair[c] = rpd_pkg::comb_ch(rpd_pkg::widen(left_r[c]), leaf[c], cfg.mode);
      end
    end
    for (int c = 0; c < 3; c++) begin
      pair_n[c] = rpd_pkg::narrow(pair[c]);
    end
    mem_idx = rpd_pkg::LINE_AW'(col_r >> 1);
    mem_we  = acc & done & ~row_r[0] & ~img_end;
    mem_re  = acc & done & row_r[0];
    emit    = acc & done & (row_r[0] | img_end);
    kind    = row_r[0] ? rpd_pkg::BLK_UPPER : rpd_pkg::BLK_PAD;
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    left_nxt     = left_r;
    s1_valid_nxt = emit;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_p1[rpd_pkg::ROW_BITS-1:0];
      end else begin
        col_nxt = col_p1[rpd_pkg::COL_BITS-1:0];
      end
      if (!done) begin
        left_nxt = pair_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      left_r     <= left_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_kind_r <= kind;
      s1_pair_r <= pair_n;
      s1_last_r <= row_end & img_end;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_idx] <= pair_n;
    end
    if (mem_re) begin
      rd_data_r <= line_mem[mem_idx];
    end
  end

  // after the s1 and read registers: join with the upper pair, or with the padding rows
  always_comb begin
    pad_zero.v = '0;
    pad_zero.n = (cfg.mode == rpd_pkg::MODE_MAX) ? 3'd1 : 3'd2;
    for (int c = 0; c < 3; c++) begin
      if (s1_kind_r == rpd_pkg::BLK_UPPER) begin
        blk[c] = rpd_pkg::comb_ch(rpd_pkg::widen(rd_data_r[c]),
                                  rpd_pkg::widen(s1_pair_r[c]), cfg.mode);
      end else begin
        blk[c] = rpd_pkg::comb_ch(rpd_pkg::widen(s1_pair_r[c]), pad_zero, cfg.mode);
      end
    end
    q_push      = s1_valid_r;
    q_item.ch   = blk;
    q_item.last = s1_last_r;
  end

endmodule

// ----- design/rpd_queue.sv -----
// rpd_queue: short block queue between the front and the finishing back end
module rpd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rpd_pkg::blk_item_t    push_item,
  input  logic                  pop,
  output logic [rpd_pkg::QAW:0] count,
  output rpd_pkg::blk_item_t    head_item
);

  rpd_pkg::blk_item_t          slot_r [rpd_pkg::QDEPTH];
  logic [rpd_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rpd_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rpd_pkg::QAW:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (rpd_pkg::QAW + 1)'(push) - (rpd_pkg::QAW + 1)'(pop);
    count      = count_r;
    head_item  = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/rpd_back.sv -----
// rpd_back: rounding divide or maximum pass, saturation and the output register
module rpd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpd_pkg::mode_t        mode,
  input  logic [rpd_pkg::QAW:0] q_count,
  input  rpd_pkg::blk_item_t    head_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rpd_pkg::rpd_out_t     out_data
);

  localparam int PROD_BITS = rpd_pkg::BLK_BITS + rpd_pkg::DIV3_SHIFT;
  localparam int SQ_BITS   = rpd_pkg::BLK_BITS + 2;
  localparam logic signed [SQ_BITS-1:0] SAT_HI =
    SQ_BITS'((longint'(1) << (rpd_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SQ_BITS-1:0] SAT_LO =
    SQ_BITS'(-(longint'(1) << (rpd_pkg::SAMPLE_BITS - 1)));

  logic                          b1_valid_r, b1_valid_nxt;
  logic [rpd_pkg::BLK_BITS-1:0]  mag_r [3];
  logic                          neg_r [3];
  logic                          inv_r [3];
  logic                          last_r;
  logic                          out_valid_r, out_valid_nxt;
  rpd_pkg::rpd_out_t             out_data_r, out_nxt;

  logic                          b_adv;
  logic                          b1_load;

  logic signed [rpd_pkg::BLK_BITS:0] v_ext [3];
  logic signed [rpd_pkg::BLK_BITS:0] v_abs [3];
  logic [rpd_pkg::BLK_BITS-1:0]      absv  [3];
  logic [rpd_pkg::BLK_BITS:0]        a1    [3];
  logic [rpd_pkg::BLK_BITS:0]        a2    [3];
  logic [PROD_BITS-1:0]              prod  [3];
  logic [rpd_pkg::BLK_BITS-1:0]      mag   [3];

  logic signed [SQ_BITS-1:0]          sq  [3];
  logic [rpd_pkg::SAMPLE_BITS-1:0]    res [3];

  always_comb begin
    b_adv         = ~out_valid_r | ~out_stall;
    b1_load       = ~b1_valid_r | b_adv;
    pop           = (q_count != '0) & b1_load;
    b1_valid_nxt  = b1_load ? pop : b1_valid_r;
    out_valid_nxt = b_adv ? b1_valid_r : out_valid_r;
  end

  // stage one: magnitude of the rounded quotient or of the maximum, sign kept apart
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_ext[c] = (rpd_pkg::BLK_BITS + 1)'(head_item.ch[c].v);
      v_abs[c] = v_ext[c][rpd_pkg::BLK_BITS] ? -v_ext[c] : v_ext[c];
      absv[c]  = v_abs[c][rpd_pkg::BLK_BITS-1:0];
      a1[c]    = {1'b0, absv[c]} + 1'b1;
      a2[c]    = {1'b0, absv[c]} + 2'd2;
      prod[c]  = a1[c][rpd_pkg::BLK_BITS-1:0] * rpd_pkg::DIV3_K;
      if (mode == rpd_pkg::MODE_MAX) begin
        mag[c] = absv[c];
      end else begin
        case (head_item.ch[c].n)
          3'd1:    mag[c] = absv[c];
          3'd2:    mag[c] = a1[c][rpd_pkg::BLK_BITS:1];
          3'd3:    mag[c] = prod[c][rpd_pkg::DIV3_SHIFT +: rpd_pkg::BLK_BITS];
          3'd4:    mag[c] = {1'b0, a2[c][rpd_pkg::BLK_BITS:2]};
          default: mag[c] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load) begin
      for (int c = 0; c < 3; c++) begin
        mag_r[c] <= mag[c];
        neg_r[c] <= head_item.ch[c].v[rpd_pkg::BLK_BITS-1];
        inv_r[c] <= (head_item.ch[c].n == 3'd0);
      end
      last_r <= head_item.last;
    end
  end

  // stage two: restore sign and clamp to the sample range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq[c] = neg_r[c] ? -$signed({2'b00, mag_r[c]}) : $signed({2'b00, mag_r[c]});
      if (inv_r[c]) begin
        res[c] = '0;
      end else if (sq[c] > SAT_HI) begin
        res[c] = SAT_HI[rpd_pkg::SAMPLE_BITS-1:0];
      end else if (sq[c] < SAT_LO) begin
        res[c] = SAT_LO[rpd_pkg::SAMPLE_BITS-1:0];
      end else begin
        res[c] = sq[c][rpd_pkg::SAMPLE_BITS-1:0];
      end
    end
    out_nxt.red_out           = res[0];
    out_nxt.green_out         = res[1];
    out_nxt.blue_out          = res[2];
    out_nxt.red_out_invalid   = inv_r[0];
    out_nxt.green_out_invalid = inv_r[1];
    out_nxt.blue_out_invalid  = inv_r[2];
    out_nxt.last_of_image     = last_r;
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/rpd_checker.sv -----
// rpd_checker: port-level assertions for the downsampler, bound to the top level
module rpd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input rpd_pkg::rpd_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.red_out_invalid || out_data.red_out == '0) &&
                  (!out_data.green_out_invalid || out_data.green_out == '0) &&
                  (!out_data.blue_out_invalid || out_data.blue_out == '0))
    else $error("invalid channel carries a nonzero value");

endmodule

bind rgb_pyramid_downsample_2x2 rpd_checker u_rpd_checker (.*);

// ----- tb/sv/rpd_downsample_checker.sv -----
// rpd_downsample_checker: predicts each half-size pixel from the watched transfers and compares
module rpd_downsample_checker
  import rpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rpd_in_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rpd_out_t          out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                blocks_due
);

  // per channel: running sum (or maximum) and member count (or valid flag)
  typedef struct packed {
    logic signed [31:0] sum;
    logic [2:0]         cnt;
  } chan_acc_t;

  typedef chan_acc_t [2:0] pix_acc_t;

  pix_acc_t    line_buf [LINE_DEPTH];
  pix_acc_t    pair_hold;
  int unsigned col;
  int unsigned row;
  int unsigned lvl_width;
  int unsigned lvl_height;
  mode_t       blend_mode;
  rpd_out_t    pending_blocks [$];
  int          errors = 0;

  function automatic chan_acc_t take(logic signed [15:0] s, logic bad);
    chan_acc_t r;
    if (bad) begin
      r.sum = '0;
      r.cnt = 3'd0;
    end else begin
      r.sum = s;
      r.cnt = 3'd1;
    end
    return r;
  endfunction

  function automatic chan_acc_t merge_chan(chan_acc_t a, chan_acc_t b, mode_t m);
    chan_acc_t r;
    r.sum = '0;
    r.cnt = 3'd0;
    if (m == MODE_AVG) begin
      r.sum = a.sum + b.sum;
      r.cnt = a.cnt + b.cnt;
    end else if (a.cnt != 0 && b.cnt != 0) begin
      r.sum = (a.sum > b.sum) ? a.sum : b.sum;
      r.cnt = 3'd1;
    end else if (a.cnt != 0) begin
      r.sum = a.sum;
      r.cnt = 3'd1;
    end else if (b.cnt != 0) begin
      r.sum = b.sum;
      r.cnt = 3'd1;
    end
    return r;
  endfunction

  function automatic pix_acc_t merge_pix(pix_acc_t a, pix_acc_t b, mode_t m);
    pix_acc_t r;
    for (int c = 0; c < 3; c++) r[c] = merge_chan(a[c], b[c], m);
    return r;
  endfunction

  // padding position: a valid zero in every channel
  function automatic pix_acc_t pad_pix();
    pix_acc_t r;
    for (int c = 0; c < 3; c++) begin
      r[c].sum = '0;
      r[c].cnt = 3'd1;
    end
    return r;
  endfunction

  // {invalid, value}: rounded mean or maximum, saturated to the sample range
  function automatic logic [16:0] settle(chan_acc_t p, mode_t m);
    longint s, mag, d, q;
    if (p.cnt == 0) return {1'b1, 16'd0};
    s = p.sum;
    d = p.cnt;
    if (m == MODE_AVG) begin
      mag = (s < 0) ? -s : s;
      q = (2 * mag + d) / (2 * d);
      if (s < 0) q = -q;
    end else begin
      q = s;
    end
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return {1'b0, q[15:0]};
  endfunction

  task automatic absorb_pixel(input rpd_in_t p);
    int unsigned w, h;
    logic row_end, img_end;
    pix_acc_t leaf, pair, blk;
    rpd_out_t res;
    w = (lvl_width == 0) ? 1 : lvl_width;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (lvl_height == 0) ? 1 : lvl_height;
    row_end = (col + 1 >= w);
    img_end = (row + 1 >= h);
    leaf[0] = take(p.red_sample, p.red_invalid);
    leaf[1] = take(p.green_sample, p.green_invalid);
    leaf[2] = take(p.blue_sample, p.blue_invalid);
    if (col[0] == 1'b0 && !row_end) begin
      pair_hold = leaf;
    end else begin
      if (col[0] == 1'b0) pair = merge_pix(leaf, pad_pix(), blend_mode);
      else pair = merge_pix(pair_hold, leaf, blend_mode);
      if (row[0] == 1'b0 && !img_end) begin
        line_buf[col >> 1] = pair;
      end else begin
        if (row[0] == 1'b0)
          blk = merge_pix(pair, merge_pix(pad_pix(), pad_pix(), blend_mode), blend_mode);
        else
          blk = merge_pix(line_buf[col >> 1], pair, blend_mode);
        {res.red_out_invalid, res.red_out}     = settle(blk[0], blend_mode);
        {res.green_out_invalid, res.green_out} = settle(blk[1], blend_mode);
        {res.blue_out_invalid, res.blue_out}   = settle(blk[2], blend_mode);
        res.last_of_image = row_end && img_end;
        pending_blocks.push_back(res);
      end
    end
    if (row_end) begin
      col = 0;
      row = img_end ? 0 : ((row + 1) & 32'hFFFF);
    end else begin
      col = (col + 1) & 32'hFFF;
    end
  endtask

  task automatic note_error();
    errors++;
  endtask

  always @(posedge clk) begin
    rpd_out_t want;
    if (!rst_n) begin
      col = 0;
      row = 0;
      pair_hold = '0;
      lvl_width = 1;
      lvl_height = 1;
      blend_mode = MODE_AVG;
      pending_blocks.delete();
    end else begin
      if (in_valid && !in_stall) absorb_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (pending_blocks.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected output pixel %h", $time, out_data);
          note_error();
        end else begin
          want = pending_blocks.pop_front();
          if (out_data.red_out !== want.red_out ||
              out_data.green_out !== want.green_out ||
              out_data.blue_out !== want.blue_out ||
              out_data.red_out_invalid !== want.red_out_invalid ||
              out_data.green_out_invalid !== want.green_out_invalid ||
              out_data.blue_out_invalid !== want.blue_out_invalid ||
              out_data.last_of_image !== want.last_of_image) begin
            if (errors < 10) begin
              $write("%0t: exp r=%0d/%b g=%0d/%b b=%0d/%b last=%b, ",
                $time, want.red_out, want.red_out_invalid, want.green_out,
                want.green_out_invalid, want.blue_out, want.blue_out_invalid,
                want.last_of_image);
              $display("got r=%0d/%b g=%0d/%b b=%0d/%b last=%b",
                out_data.red_out, out_data.red_out_invalid,
                out_data.green_out, out_data.green_out_invalid, out_data.blue_out,
                out_data.blue_out_invalid, out_data.last_of_image);
            end
            note_error();
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IN_WIDTH:     lvl_width = cfg_wdata[W_BITS-1:0];
          CFG_IN_HEIGHT:    lvl_height = cfg_wdata[H_BITS-1:0];
          CFG_COMBINE_MODE: blend_mode = mode_t'(cfg_wdata[0]);
          default: ;
        endcase
      end
    end
    blocks_due <= pending_blocks.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/sv/rgb_pyramid_downsample_2x2_test.sv -----
// rgb_pyramid_downsample_2x2_test: stimulus, handshake pacing and verdict for the downsampler
module rgb_pyramid_downsample_2x2_test;
  import rpd_pkg::*;

  // number of random pixels before the stimulus stops
  localparam int RANDOM_PIXELS = 1600;
  // cycles allowed for the block to settle with no transfer in flight
  localparam int SETTLE_CYCLES = 16;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  rpd_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rpd_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_IN_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int blocks_due;

  // sender pacing state: transfers left in the current burst
  int burst_left = 0;
  // receiver pacing state: current stall style and cycles until it changes
  int stall_style = 0;
  int stall_left = 0;
  // random pixels sent so far
  int sent = 0;

  rgb_pyramid_downsample_2x2 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rpd_downsample_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .blocks_due (blocks_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: switches among free flow, light and heavy random stalls and a
  // periodic stall, each held for a random stretch of cycles
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // build a pixel; bad holds the invalid flags as {red, green, blue}
  function automatic rpd_in_t mk_pixel(int r, int g, int b, logic [2:0] bad);
    rpd_in_t p;
    p.red_sample = 16'(r);
    p.green_sample = 16'(g);
    p.blue_sample = 16'(b);
    {p.red_invalid, p.green_invalid, p.blue_invalid} = bad;
    return p;
  endfunction

  // samples lean toward the range ends and toward small values where ties show up
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rpd_in_t rand_pixel(int bad_pct);
    rpd_in_t p;
    p.red_sample = rand_sample();
    p.green_sample = rand_sample();
    p.blue_sample = rand_sample();
    p.red_invalid = ($urandom_range(0, 99) < bad_pct);
    p.green_invalid = ($urandom_range(0, 99) < bad_pct);
    p.blue_invalid = ($urandom_range(0, 99) < bad_pct);
    return p;
  endfunction

  // one pixel transfer; a new burst may open with a gap of idle cycles
  task automatic send_pixel(input rpd_in_t p);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        // long stretch with no idling
        burst_left = $urandom_range(100, 400);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, wait for every predicted pixel, then let the pipeline settle;
  // the first edge lets the checker count a transfer taken on the last edge
  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blocks_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers, written back to back while the block is idle
  task automatic configure(input logic [15:0] w, input logic [15:0] h, input mode_t m);
    go_quiet();
    cfg_we <= 1'b1;
    cfg_index <= CFG_IN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_COMBINE_MODE;
    cfg_wdata <= {15'd0, m};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one whole level in raster order; the mode may flip after row flip_row
  task automatic send_level(input int w, input int h, input mode_t m, input int bad_pct,
                            input int flip_row);
    configure(w, h, m);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        send_pixel(rand_pixel(bad_pct));
        sent++;
      end
      if (y == flip_row) begin
        m = (m == MODE_AVG) ? MODE_MAX : MODE_AVG;
        configure(w, h, m);
      end
    end
  endtask

  initial begin
    int w, h, bad_pct, flip_row;
    mode_t m;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at their reset values: one pixel is a whole padded level
    send_pixel(mk_pixel(32767, -32768, 0, 3'b001));

    // width and height of zero act as one; maximum against the padding zeros
    configure(0, 0, MODE_MAX);
    send_pixel(mk_pixel(-5, 7, 0, 3'b111));
    send_pixel(mk_pixel(32767, -32768, -1, 3'b000));

    // average: half-way ties round away from zero, all-invalid channel,
    // division by three
    configure(2, 2, MODE_AVG);
    send_pixel(mk_pixel(2, -2, 32767, 3'b000));
    send_pixel(mk_pixel(0, 0, 32767, 3'b000));
    send_pixel(mk_pixel(0, 0, 32767, 3'b000));
    send_pixel(mk_pixel(0, 0, 32767, 3'b000));
    send_pixel(mk_pixel(-32768, 0, 1, 3'b010));
    send_pixel(mk_pixel(-32768, 0, 1, 3'b010));
    send_pixel(mk_pixel(-32768, 0, 0, 3'b010));
    send_pixel(mk_pixel(-32768, 0, 0, 3'b011));

    // maximum skips invalid members
    configure(2, 2, MODE_MAX);
    send_pixel(mk_pixel(-5, 0, 32767, 3'b010));
    send_pixel(mk_pixel(-3, 0, -32768, 3'b010));
    send_pixel(mk_pixel(0, 0, 0, 3'b110));
    send_pixel(mk_pixel(-7, 0, 1, 3'b010));

    // mode flips between the rows: the stored sums are taken as maxima and
    // saturate at both ends of the range
    configure(2, 2, MODE_AVG);
    send_pixel(mk_pixel(32767, -32768, 5, 3'b000));
    send_pixel(mk_pixel(32767, -32768, 6, 3'b000));
    configure(2, 2, MODE_MAX);
    send_pixel(mk_pixel(0, 0, 1, 3'b010));
    send_pixel(mk_pixel(0, 0, 2, 3'b010));

    // width shrinks mid-row: the counters run on and the row ends on the
    // next pixel; the row below only reads pairs written above it
    configure(8, 2, MODE_AVG);
    repeat (5) send_pixel(rand_pixel(20));
    configure(4, 2, MODE_AVG);
    repeat (5) send_pixel(rand_pixel(20));

    // width written far above the line buffer does not end the row early;
    // a narrower width then closes it and the row below reads the stored pairs
    configure(16'hFFFF, 2, MODE_AVG);
    repeat (9) send_pixel(rand_pixel(20));
    configure(10, 2, MODE_AVG);
    repeat (11) send_pixel(rand_pixel(20));

    // tallest height, then cut short: the next even row closes the level
    configure(0, 16'hFFFF, MODE_AVG);
    repeat (4) send_pixel(rand_pixel(20));
    configure(0, 1, MODE_AVG);
    send_pixel(rand_pixel(20));

    // random levels: mostly narrow, a few wide, odd sizes for padding,
    // invalid rates from none to nearly all, some with a mode flip
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 16);
        7, 8: w = $urandom_range(17, 64);
        default: w = $urandom_range(65, 300);
      endcase
      if (w > 64) h = $urandom_range(1, 4);
      else if ($urandom_range(0, 4) == 0) h = $urandom_range(7, 16);
      else h = $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: bad_pct = 0;
        1: bad_pct = 10;
        2: bad_pct = 40;
        default: bad_pct = 95;
      endcase
      m = mode_t'($urandom_range(0, 1));
      flip_row = -1;
      if (h > 1 && $urandom_range(0, 5) == 0) flip_row = $urandom_range(0, h - 2);
      send_level(w, h, m, bad_pct, flip_row);
    end

    // drain and give the verdict
    go_quiet();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard limit well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
